>>> design/sha256_pkg.sv
// SHA-256 package: command codes, round constants, initial hash values and helpers.
// Used by the stream hasher top level.
package sha256_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned Rounds      = 64;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned LenPos      = 56;
  localparam logic [7:0]  PadByte     = 8'h80;
  localparam logic [63:0] BlockBits   = 64'd512;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[idx];
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[idx];
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> design/sha256_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the message block buffer of the hasher.
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> design/sha256_stream_hasher_top.sv
// Streaming SHA-256 hasher top level: sequencer, round unit, schedule and output stage.
// Depends on sha256_pkg and sha256_ram.
//
// One word per command. An absorb word stores one byte; the 64th byte of a block also
// starts a compression: the block is read out of the byte RAM and then compressed by
// one shared round unit at one round per cycle, followed by the chain update, during
// all of which s_axis_tready is low. A finish or peek word runs the padding blocks
// (one, or two when 56 or more bytes are pending) through the same path on a working
// copy of the chain, then offers the eight digest words on the master side, word 0
// first, tlast on word 7, one word per cycle while m_axis_tready is high. A finish word
// then restores the initial chain in a clean-up state after the last digest word.
// Rate is set by the single round unit and the byte-wide buffer port.
module sha256_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] cmd, [9:2] data_byte, [15:10] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,  // bytes from RAM or padding into the schedule
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,  // chain update
    ST_OUT   = 6'b010000,
    ST_CLEAN = 6'b100000   // finish: reset chain after output
  } state_e;

  state_e state_q, state_d;

  logic [31:0] h_q [8];     // chain hash
  logic [31:0] d_q [8];     // digest working copy
  logic [31:0] v_q [8];     // round variables
  logic [31:0] w_q [16];    // message schedule window
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [6:0]  cnt_q;       // load counter / round counter
  logic        dig_q;       // compressing for a digest, not the chain
  logic        second_q;    // second padding block pending
  logic        fin_q;       // finish rather than peek
  logic [2:0]  oidx_q;

  logic        in_acc;
  logic [1:0]  in_cmd;
  logic [7:0]  in_byte;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_cmd  = s_axis_tdata[1:0];
  assign in_byte = s_axis_tdata[9:2];
  assign s_axis_tready = (state_q == ST_IDLE);

  // Byte RAM: written on absorb, read sequentially during a load.
  logic       ram_we;
  logic [5:0] ram_addr;
  logic [7:0] ram_rdata;
  assign ram_we   = in_acc && (in_cmd == sha256_pkg::CMD_ABSORB);
  assign ram_addr = ram_we ? fill_q : cnt_q[5:0];

  sha256_ram #(.Width(8), .Depth(sha256_pkg::BlockBytes)) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_byte),
    .rdata_o(ram_rdata)
  );

  // second_q_done marks the block that follows a long tail: all zeros plus the length.
  logic second_q_done;
  logic blk2_q;
  assign second_q_done = blk2_q;

  // Byte fed into the schedule during a load; byte position is cnt_q - 1.
  logic [5:0]  pos;
  logic [63:0] len;
  logic [7:0]  load_byte;
  assign pos = cnt_q[5:0] - 6'd1;
  assign len = bits_q + {55'd0, fill_q, 3'd0};
  always_comb begin
    load_byte = 8'd0;
    if (!dig_q) begin
      load_byte = ram_rdata;
    end else if (pos >= 6'(sha256_pkg::LenPos) && !second_q) begin
      load_byte = len[8'(63 - 8*(pos - 6'(sha256_pkg::LenPos))) -: 8];
    end else if (pos < fill_q && !second_q_done) begin
      load_byte = ram_rdata;
    end else if (pos == fill_q && !second_q_done) begin
      load_byte = sha256_pkg::PadByte;
    end
  end

  // Shared round unit.
  logic [31:0] s0, s1, t1, t2, ch, maj, wn;
  always_comb begin
    s1  = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11) ^
          sha256_pkg::ror(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1 + ch + sha256_pkg::round_k(cnt_q[5:0]) + w_q[0];
    s0  = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13) ^
          sha256_pkg::ror(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0 + maj;
    wn  = w_q[0] + (sha256_pkg::ror(w_q[1], 7) ^ sha256_pkg::ror(w_q[1], 18) ^
          (w_q[1] >> 3)) + w_q[9] + (sha256_pkg::ror(w_q[14], 17) ^
          sha256_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_cmd == sha256_pkg::CMD_ABSORB) begin
            if (fill_q == 6'd63) state_d = ST_LOAD;
          end else if (in_cmd == sha256_pkg::CMD_FINISH ||
                       in_cmd == sha256_pkg::CMD_PEEK) begin
            state_d = ST_LOAD;
          end else begin
            state_d = state_q;
          end
        end
      end
      ST_LOAD:  if (cnt_q == 7'd64) state_d = ST_ROUND;
      ST_ROUND: if (cnt_q == 7'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (!dig_q) state_d = ST_IDLE;
        else if (second_q) state_d = ST_LOAD;
        else state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready && oidx_q == 3'd7) state_d = fin_q ? ST_CLEAN : ST_IDLE;
      end
      ST_CLEAN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      bits_q   <= '0;
      cnt_q    <= '0;
      dig_q    <= 1'b0;
      second_q <= 1'b0;
      blk2_q   <= 1'b0;
      fin_q    <= 1'b0;
      oidx_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc && in_cmd == sha256_pkg::CMD_ABSORB) begin
            fill_q <= fill_q + 6'd1;
            dig_q  <= 1'b0;
          end else if (in_acc && (in_cmd == sha256_pkg::CMD_FINISH ||
                                  in_cmd == sha256_pkg::CMD_PEEK)) begin
            dig_q    <= 1'b1;
            fin_q    <= (in_cmd == sha256_pkg::CMD_FINISH);
            second_q <= (fill_q >= 6'(sha256_pkg::LenPos));
            blk2_q   <= 1'b0;
            for (int i = 0; i < 8; i++) d_q[i] <= h_q[i];
          end
        end
        ST_LOAD: begin
          if (cnt_q != 7'd0) begin
            w_q[4'(pos[5:2])] <= {w_q[4'(pos[5:2])][23:0], load_byte};
          end
          if (cnt_q == 7'd64) begin
            cnt_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= dig_q ? d_q[i] : h_q[i];
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        ST_ROUND: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wn;
          cnt_q <= cnt_q + 7'd1;
        end
        ST_ADD: begin
          cnt_q  <= '0;
          oidx_q <= '0;
          if (dig_q) begin
            for (int i = 0; i < 8; i++) d_q[i] <= d_q[i] + v_q[i];
            if (second_q) begin
              second_q <= 1'b0;
              blk2_q   <= 1'b1;
            end
          end else begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
            bits_q <= bits_q + sha256_pkg::BlockBits;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) oidx_q <= oidx_q + 3'd1;
        end
        ST_CLEAN: begin
          fill_q <= '0;
          bits_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {5'd0, oidx_q, d_q[oidx_q]};
  assign m_axis_tlast  = (oidx_q == 3'd7);

endmodule

>>> design/sha256_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to its top level.
// Depends on sha256_stream_hasher_top ports only.
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // Input side is never ready while digest words are offered.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
  // tlast marks word index seven exactly.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast mismatch");
  // A stalled output word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // After a taken word that is not last, the next index follows.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
    m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("word order broken");
endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (.*);
